// ===== hdl/seg2d_pkg.sv =====
// Shared types and constants for the 2D segment intersection pipeline.
// No dependencies; every other file refers to this package by scoped names.
package seg2d_pkg;

   // Widths of the exact intermediate values.
   localparam int CW  = 32;           // coordinate width (Q16.16)
   localparam int DW  = CW + 1;       // coordinate difference
   localparam int PW  = 2 * DW;       // product of two differences
   localparam int EW  = PW + 1;       // cross-product terms d, e, f
   localparam int FW  = EW - 2;       // magnitude of d or f inside the span
   localparam int AW  = CW;           // magnitude of a difference of the first segment
   localparam int DLO = 33;           // low slice of |d| for the split multiply
   localparam int DHI = FW - DLO;     // high slice of |d|
   localparam int NW  = FW + AW;      // numerator |d| * |A|
   localparam int QW  = AW;           // quotient bits before rounding
   localparam int RW  = QW + 1;       // rounded quotient

   // Status codes.
   localparam logic [1:0] ST_MISS     = 2'd0;
   localparam logic [1:0] ST_HIT      = 2'd1;
   localparam logic [1:0] ST_PARALLEL = 2'd2;

   typedef struct packed {
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by_coord;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic signed [CW-1:0] hit_x;
      logic signed [CW-1:0] hit_y;
   } rsp_type;

   // Per-item control that rides beside the arithmetic.
   typedef struct packed {
      logic [1:0]           status;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic                 neg_x;
      logic                 neg_y;
   } side_type;

endpackage

// ===== hdl/seg2d_front.sv =====
// Front end: differences and box rejection, cross products, d/e/f terms and
// span classification over four register stages. Uses seg2d_pkg.
module seg2d_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  seg2d_pkg::req_type            in_req,
   output logic                          out_valid,
   output seg2d_pkg::side_type           out_side,
   output logic [seg2d_pkg::FW-1:0]      out_dmag,
   output logic [seg2d_pkg::FW-1:0]      out_fmag,
   output logic [seg2d_pkg::AW-1:0]      out_axm,
   output logic [seg2d_pkg::AW-1:0]      out_aym
);

   localparam int DW = seg2d_pkg::DW;
   localparam int PW = seg2d_pkg::PW;
   localparam int EW = seg2d_pkg::EW;
   localparam int FW = seg2d_pkg::FW;
   localparam int AW = seg2d_pkg::AW;
   localparam int CW = seg2d_pkg::CW;

   // Stage 1: exact differences and bounding box rejection.
   logic signed [DW-1:0] axd_in, ayd_in, bxd_in, byd_in, cxd_in, cyd_in;
   logic signed [CW-1:0] lox, hix, loy, hiy;
   logic                 rej_x, rej_y;
   logic signed [DW-1:0] axd1_ff, ayd1_ff, bxd1_ff, byd1_ff, cxd1_ff, cyd1_ff;
   logic signed [CW-1:0] x1_1_ff, y1_1_ff;
   logic                 rej1_ff, v1_ff;

   assign axd_in = $signed({in_req.bx[CW-1], in_req.bx}) - $signed({in_req.ax[CW-1], in_req.ax});
   assign ayd_in = $signed({in_req.by_coord[CW-1], in_req.by_coord})
                 - $signed({in_req.ay[CW-1], in_req.ay});
   assign bxd_in = $signed({in_req.cx[CW-1], in_req.cx}) - $signed({in_req.dx[CW-1], in_req.dx});
   assign byd_in = $signed({in_req.cy[CW-1], in_req.cy}) - $signed({in_req.dy[CW-1], in_req.dy});
   assign cxd_in = $signed({in_req.ax[CW-1], in_req.ax}) - $signed({in_req.cx[CW-1], in_req.cx});
   assign cyd_in = $signed({in_req.ay[CW-1], in_req.ay}) - $signed({in_req.cy[CW-1], in_req.cy});

   always_comb begin
      lox = axd_in[DW-1] ? in_req.bx : in_req.ax;
      hix = axd_in[DW-1] ? in_req.ax : in_req.bx;
      loy = ayd_in[DW-1] ? in_req.by_coord : in_req.ay;
      hiy = ayd_in[DW-1] ? in_req.ay : in_req.by_coord;
      if (!bxd_in[DW-1] && (bxd_in != '0)) begin
         rej_x = (hix < in_req.dx) || (in_req.cx < lox);
      end else begin
         rej_x = (hix < in_req.cx) || (in_req.dx < lox);
      end
      if (!byd_in[DW-1] && (byd_in != '0)) begin
         rej_y = (hiy < in_req.dy) || (in_req.cy < loy);
      end else begin
         rej_y = (hiy < in_req.cy) || (in_req.dy < loy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         axd1_ff <= axd_in;
         ayd1_ff <= ayd_in;
         bxd1_ff <= bxd_in;
         byd1_ff <= byd_in;
         cxd1_ff <= cxd_in;
         cyd1_ff <= cyd_in;
         x1_1_ff <= in_req.ax;
         y1_1_ff <= in_req.ay;
         rej1_ff <= rej_x || rej_y;
      end
   end

   // Stage 2: the six signed cross products.
   logic signed [PW-1:0] pd0_in, pd1_in, pf0_in, pf1_in, pe0_in, pe1_in;
   logic signed [PW-1:0] pd0_ff, pd1_ff, pf0_ff, pf1_ff, pe0_ff, pe1_ff;
   logic signed [DW-1:0] axd2_ff, ayd2_ff;
   logic signed [CW-1:0] x1_2_ff, y1_2_ff;
   logic                 rej2_ff, v2_ff;

   assign pd0_in = byd1_ff * cxd1_ff;
   assign pd1_in = bxd1_ff * cyd1_ff;
   assign pf0_in = ayd1_ff * bxd1_ff;
   assign pf1_in = axd1_ff * byd1_ff;
   assign pe0_in = axd1_ff * cyd1_ff;
   assign pe1_in = ayd1_ff * cxd1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pd0_ff  <= pd0_in;
         pd1_ff  <= pd1_in;
         pf0_ff  <= pf0_in;
         pf1_ff  <= pf1_in;
         pe0_ff  <= pe0_in;
         pe1_ff  <= pe1_in;
         axd2_ff <= axd1_ff;
         ayd2_ff <= ayd1_ff;
         x1_2_ff <= x1_1_ff;
         y1_2_ff <= y1_1_ff;
         rej2_ff <= rej1_ff;
      end
   end

   // Stage 3: the terms d, e and f.
   logic signed [EW-1:0] d_in, e_in, f_in;
   logic signed [EW-1:0] d3_ff, e3_ff, f3_ff;
   logic signed [DW-1:0] axd3_ff, ayd3_ff;
   logic signed [CW-1:0] x1_3_ff, y1_3_ff;
   logic                 rej3_ff, v3_ff;

   assign d_in = EW'(pd0_ff) - EW'(pd1_ff);
   assign f_in = EW'(pf0_ff) - EW'(pf1_ff);
   assign e_in = EW'(pe0_ff) - EW'(pe1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff   <= d_in;
         e3_ff   <= e_in;
         f3_ff   <= f_in;
         axd3_ff <= axd2_ff;
         ayd3_ff <= ayd2_ff;
         x1_3_ff <= x1_2_ff;
         y1_3_ff <= y1_2_ff;
         rej3_ff <= rej2_ff;
      end
   end

   // Stage 4: span tests, status and magnitudes for the divider.
   logic                 f_pos, f_zero, d_ok, e_ok;
   logic signed [EW-1:0] dneg, fneg;
   logic signed [DW-1:0] axneg, ayneg;
   seg2d_pkg::side_type  side_in;
   seg2d_pkg::side_type  side4_ff;
   logic [FW-1:0]        dmag4_ff, fmag4_ff;
   logic [AW-1:0]        axm4_ff, aym4_ff;
   logic                 v4_ff;

   always_comb begin
      f_zero = (f3_ff == '0);
      f_pos  = !f3_ff[EW-1] && !f_zero;
      if (f_pos) begin
         d_ok = !d3_ff[EW-1] && !(d3_ff > f3_ff);
         e_ok = !e3_ff[EW-1] && !(e3_ff > f3_ff);
      end else begin
         d_ok = (d3_ff[EW-1] || (d3_ff == '0)) && !(d3_ff < f3_ff);
         e_ok = (e3_ff[EW-1] || (e3_ff == '0)) && !(e3_ff < f3_ff);
      end
      dneg  = -d3_ff;
      fneg  = -f3_ff;
      axneg = -axd3_ff;
      ayneg = -ayd3_ff;
      side_in.x1    = x1_3_ff;
      side_in.y1    = y1_3_ff;
      side_in.neg_x = d3_ff[EW-1] ^ f3_ff[EW-1] ^ axd3_ff[DW-1];
      side_in.neg_y = d3_ff[EW-1] ^ f3_ff[EW-1] ^ ayd3_ff[DW-1];
      if (rej3_ff || !d_ok || !e_ok) begin
         side_in.status = seg2d_pkg::ST_MISS;
      end else if (f_zero) begin
         side_in.status = seg2d_pkg::ST_PARALLEL;
      end else begin
         side_in.status = seg2d_pkg::ST_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side4_ff <= side_in;
         dmag4_ff <= d3_ff[EW-1] ? dneg[FW-1:0] : d3_ff[FW-1:0];
         fmag4_ff <= f3_ff[EW-1] ? fneg[FW-1:0] : f3_ff[FW-1:0];
         axm4_ff  <= axd3_ff[DW-1] ? axneg[AW-1:0] : axd3_ff[AW-1:0];
         aym4_ff  <= ayd3_ff[DW-1] ? ayneg[AW-1:0] : ayd3_ff[AW-1:0];
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = side4_ff;
   assign out_dmag  = dmag4_ff;
   assign out_fmag  = fmag4_ff;
   assign out_axm   = axm4_ff;
   assign out_aym   = aym4_ff;

endmodule

// ===== hdl/seg2d_mul.sv =====
// Numerator multiply: |d| times |Ax| and |Ay| as split partial products over
// two register stages. Uses seg2d_pkg.
module seg2d_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  seg2d_pkg::side_type           in_side,
   input  logic [seg2d_pkg::FW-1:0]      in_dmag,
   input  logic [seg2d_pkg::FW-1:0]      in_fmag,
   input  logic [seg2d_pkg::AW-1:0]      in_axm,
   input  logic [seg2d_pkg::AW-1:0]      in_aym,
   output logic                          out_valid,
   output seg2d_pkg::side_type           out_side,
   output logic [seg2d_pkg::FW-1:0]      out_fmag,
   output logic [seg2d_pkg::NW-1:0]      out_numx,
   output logic [seg2d_pkg::NW-1:0]      out_numy
);

   localparam int FW  = seg2d_pkg::FW;
   localparam int AW  = seg2d_pkg::AW;
   localparam int NW  = seg2d_pkg::NW;
   localparam int DLO = seg2d_pkg::DLO;
   localparam int DHI = seg2d_pkg::DHI;

   // Stage 5: low and high partial products for each axis.
   logic [DLO+AW-1:0] plx_in, ply_in, plx_ff, ply_ff;
   logic [DHI+AW-1:0] phx_in, phy_in, phx_ff, phy_ff;
   seg2d_pkg::side_type side5_ff;
   logic [FW-1:0]     fmag5_ff;
   logic              v5_ff;

   assign plx_in = in_dmag[DLO-1:0] * in_axm;
   assign ply_in = in_dmag[DLO-1:0] * in_aym;
   assign phx_in = in_dmag[FW-1:DLO] * in_axm;
   assign phy_in = in_dmag[FW-1:DLO] * in_aym;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plx_ff   <= plx_in;
         ply_ff   <= ply_in;
         phx_ff   <= phx_in;
         phy_ff   <= phy_in;
         side5_ff <= in_side;
         fmag5_ff <= in_fmag;
      end
   end

   // Stage 6: combine the partial products into full numerators.
   logic [NW-1:0]     numx_ff, numy_ff;
   seg2d_pkg::side_type side6_ff;
   logic [FW-1:0]     fmag6_ff;
   logic              v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         numx_ff  <= NW'(plx_ff) + (NW'(phx_ff) << DLO);
         numy_ff  <= NW'(ply_ff) + (NW'(phy_ff) << DLO);
         side6_ff <= side5_ff;
         fmag6_ff <= fmag5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign out_side  = side6_ff;
   assign out_fmag  = fmag6_ff;
   assign out_numx  = numx_ff;
   assign out_numy  = numy_ff;

endmodule

// ===== hdl/seg2d_div.sv =====
// Pipelined restoring divider for both axes, one quotient bit per stage,
// followed by a round-to-nearest stage. Uses seg2d_pkg.
module seg2d_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  seg2d_pkg::side_type           in_side,
   input  logic [seg2d_pkg::FW-1:0]      in_fmag,
   input  logic [seg2d_pkg::NW-1:0]      in_numx,
   input  logic [seg2d_pkg::NW-1:0]      in_numy,
   output logic                          out_valid,
   output seg2d_pkg::side_type           out_side,
   output logic [seg2d_pkg::RW-1:0]      out_qx,
   output logic [seg2d_pkg::RW-1:0]      out_qy
);

   localparam int FW = seg2d_pkg::FW;
   localparam int NW = seg2d_pkg::NW;
   localparam int QW = seg2d_pkg::QW;
   localparam int RW = seg2d_pkg::RW;

   // Stage arrays; entry 0 is the input side of the first bit stage.
   logic [NW-1:0]       remx [0:QW];
   logic [NW-1:0]       remy [0:QW];
   logic [QW-1:0]       qx   [0:QW];
   logic [QW-1:0]       qy   [0:QW];
   logic [FW-1:0]       fmag [0:QW];
   seg2d_pkg::side_type side [0:QW];
   logic [QW:0]         vld;

   assign remx[0] = in_numx;
   assign remy[0] = in_numy;
   assign qx[0]   = '0;
   assign qy[0]   = '0;
   assign fmag[0] = in_fmag;
   assign side[0] = in_side;
   assign vld[0]  = in_valid;

   // One quotient bit per stage, most significant bit first.
   for (genvar i = 0; i < QW; i++) begin : g_bit
      localparam int B = QW - 1 - i;
      logic [NW:0]   tx, ty;
      logic [NW-1:0] den;
      logic [NW-1:0] remx_ff, remy_ff;
      logic [QW-1:0] qx_ff, qy_ff;
      logic [FW-1:0] fmag_ff;
      seg2d_pkg::side_type side_ff;
      logic          v_ff;

      assign den = NW'(fmag[i]) << B;
      assign tx  = {1'b0, remx[i]} - {1'b0, den};
      assign ty  = {1'b0, remy[i]} - {1'b0, den};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= vld[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            remx_ff <= tx[NW] ? remx[i] : tx[NW-1:0];
            remy_ff <= ty[NW] ? remy[i] : ty[NW-1:0];
            qx_ff   <= qx[i] | (tx[NW] ? '0 : (QW'(1) << B));
            qy_ff   <= qy[i] | (ty[NW] ? '0 : (QW'(1) << B));
            fmag_ff <= fmag[i];
            side_ff <= side[i];
         end
      end

      assign remx[i+1] = remx_ff;
      assign remy[i+1] = remy_ff;
      assign qx[i+1]   = qx_ff;
      assign qy[i+1]   = qy_ff;
      assign fmag[i+1] = fmag_ff;
      assign side[i+1] = side_ff;
      assign vld[i+1]  = v_ff;
   end

   // Round to nearest: bump when twice the remainder reaches the divisor.
   logic                rndx, rndy;
   logic [RW-1:0]       qrx_ff, qry_ff;
   seg2d_pkg::side_type sider_ff;
   logic                vr_ff;

   assign rndx = {remx[QW][FW-1:0], 1'b0} >= {1'b0, fmag[QW]};
   assign rndy = {remy[QW][FW-1:0], 1'b0} >= {1'b0, fmag[QW]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (adv) begin
         vr_ff <= vld[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qrx_ff   <= {1'b0, qx[QW]} + RW'(rndx);
         qry_ff   <= {1'b0, qy[QW]} + RW'(rndy);
         sider_ff <= side[QW];
      end
   end

   assign out_valid = vr_ff;
   assign out_side  = sider_ff;
   assign out_qx    = qrx_ff;
   assign out_qy    = qry_ff;

endmodule

// ===== hdl/segment_intersection_2d.sv =====
// Top level of the 2D segment intersection pipeline: front end, numerator
// multiply, divider and the result register. Uses seg2d_pkg, seg2d_front, seg2d_mul and seg2d_div.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  seg2d_pkg::req_type (two segments)
//   rsp_      out        rsp_valid/rsp_stall  seg2d_pkg::rsp_type (status, point)
//
// One request is taken per cycle unless the response is stalled. It passes
// through 40 registers: four front stages, two multiply stages, 32 divider
// bit stages, one rounding stage and the result register. The divider's bit
// stages set the depth.
// Reset is synchronous and clears only the valid bits.
// A stalled response freezes the whole pipeline, so req_stall follows it.
module segment_intersection_2d (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  seg2d_pkg::req_type   req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output seg2d_pkg::rsp_type   rsp
);

   localparam int FW = seg2d_pkg::FW;
   localparam int AW = seg2d_pkg::AW;
   localparam int NW = seg2d_pkg::NW;
   localparam int RW = seg2d_pkg::RW;
   localparam int CW = seg2d_pkg::CW;

   logic                adv;
   logic                rsp_valid_ff;
   logic                fr_valid, mu_valid, dv_valid;
   seg2d_pkg::side_type fr_side, mu_side, dv_side;
   logic [FW-1:0]       fr_dmag, fr_fmag, mu_fmag;
   logic [AW-1:0]       fr_axm, fr_aym;
   logic [NW-1:0]       mu_numx, mu_numy;
   logic [RW-1:0]       dv_qx, dv_qy;

   // The pipeline moves unless a finished response is held back.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   seg2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_req    (req),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_dmag  (fr_dmag),
      .out_fmag  (fr_fmag),
      .out_axm   (fr_axm),
      .out_aym   (fr_aym)
   );

   seg2d_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_dmag   (fr_dmag),
      .in_fmag   (fr_fmag),
      .in_axm    (fr_axm),
      .in_aym    (fr_aym),
      .out_valid (mu_valid),
      .out_side  (mu_side),
      .out_fmag  (mu_fmag),
      .out_numx  (mu_numx),
      .out_numy  (mu_numy)
   );

   seg2d_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mu_valid),
      .in_side   (mu_side),
      .in_fmag   (mu_fmag),
      .in_numx   (mu_numx),
      .in_numy   (mu_numy),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy)
   );

   // Result register: apply the sign, add the start point, zero non-hits.
   seg2d_pkg::rsp_type   rsp_in, rsp_ff;
   logic signed [RW:0]   offx, offy;
   logic signed [RW:0]   sumx, sumy;

   always_comb begin
      offx = dv_side.neg_x ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      offy = dv_side.neg_y ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
      sumx = (RW+1)'(dv_side.x1) + offx;
      sumy = (RW+1)'(dv_side.y1) + offy;
      rsp_in.status = dv_side.status;
      if (dv_side.status == seg2d_pkg::ST_HIT) begin
         rsp_in.hit_x = sumx[CW-1:0];
         rsp_in.hit_y = sumy[CW-1:0];
      end else begin
         rsp_in.hit_x = '0;
         rsp_in.hit_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hdl/seg2d_check.sv =====
// Port-level checker for segment_intersection_2d and its bind statement.
// Uses seg2d_pkg; sees only the top level's ports.
module seg2d_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input seg2d_pkg::rsp_type rsp
);

   // A held response keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   // Requests are held back only by a stalled response.
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without back pressure");

   // Responses other than a hit carry a zero point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != seg2d_pkg::ST_HIT) |-> (rsp.hit_x == '0) && (rsp.hit_y == '0))
      else $error("non-hit response with nonzero point");

   // Nothing is shown right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind segment_intersection_2d seg2d_check u_check (.*);
